[design/chr_pkg.sv]
// ----------------------------------------------------------------------------
// chr_pkg
// types and constants for the consistent hashing ring unit
// ----------------------------------------------------------------------------
package chr_pkg;

    localparam logic [31:0] MIX_MUL       = 32'h045d_9f3b;
    localparam logic [31:0] REPLICA_STEP1 = 32'd100000;
    localparam logic [31:0] REPLICA_STEP2 = 32'd200000;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX_A,
        S_MIX_B,
        S_MIX_C,
        S_FIND,
        S_SHIFT,
        S_PUT,
        S_COUNT,
        S_DEL,
        S_LOOK,
        S_LOOK_RD,
        S_DONE
    } t_state;

endpackage

[design/consistent_hash_ring_unit.sv]
// ----------------------------------------------------------------------------
// consistent_hash_ring_unit
// sorted ring of server replicas with add, remove and owner lookup
// ----------------------------------------------------------------------------
// add hashes each of three replicas and shifts it into sorted place, remove counts
// then compacts, lookup scans for the first entry at or above the key; one item at a
// time, set by the ring memory walked by the sequencer and the shared 32x32 multiplier
// reset clears the entry count and control; ring contents are not cleared
module consistent_hash_ring_unit #(
    parameter int MAX_SERVERS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_command,
    input  logic [16:0]          i_server_id,
    input  logic [31:0]          i_key_hash,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_status,
    output logic [16:0]          o_owner_server,
    output logic [7:0]           o_owner_slot
);
    import chr_pkg::*;

    localparam int DEPTH = 3 * MAX_SERVERS;
    localparam int AW    = $clog2(DEPTH + 1);

    t_state r_state, n_state;

    logic [1:0]    r_cmd;
    logic [16:0]   r_sid;
    logic [31:0]   r_key;
    logic [AW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic [1:0]    r_rep, n_rep;
    logic [1:0]    r_hit, n_hit;
    logic [31:0]   r_x, n_x;
    logic [31:0]   r_pos;
    logic          r_ovalid, n_ovalid;
    logic [1:0]    r_status, n_status;
    logic [16:0]   r_owner, n_owner;
    logic [7:0]    r_slot, n_slot;

    // ring memory, one write port and one read port, registered read
    logic [31:0]   m_pos [DEPTH];
    logic [16:0]   m_own [DEPTH];
    logic [31:0]   r_rd_pos;
    logic [16:0]   r_rd_own;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_pos;
    logic [16:0]   wr_own;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            m_pos[wr_addr] <= wr_pos;
            m_own[wr_addr] <= wr_own;
        end
        r_rd_pos <= m_pos[rd_addr];
        r_rd_own <= m_own[rd_addr];
    end

    // shared multiplier: one xor-shift-multiply round per cycle
    logic [31:0] mix_in;
    logic [63:0] mix_prod;
    assign mix_in   = (r_x >> 16) ^ r_x;
    assign mix_prod = {32'd0, mix_in} * {32'd0, MIX_MUL};

    logic accept_in;
    assign accept_in = i_valid && !o_stall;
    assign o_stall   = (r_state != S_IDLE) || r_ovalid;

    // replica ids are hashed at full 32-bit width
    logic [31:0] rep_id;
    always_comb begin
        case (r_rep)
            2'd1:    rep_id = {15'd0, r_sid} + REPLICA_STEP1;
            2'd2:    rep_id = {15'd0, r_sid} + REPLICA_STEP2;
            default: rep_id = {15'd0, r_sid};
        endcase
    end

    // rd_addr presents address for next cycle's data
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_rep    = r_rep;
        n_hit    = r_hit;
        n_x      = r_x;
        n_ovalid = r_ovalid;
        n_status = r_status;
        n_owner  = r_owner;
        n_slot   = r_slot;
        wr_en    = 1'b0;
        wr_addr  = r_idx;
        wr_pos   = r_pos;
        wr_own   = r_sid;
        rd_addr  = r_idx;
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    n_idx    = '0;
                    n_rep    = '0;
                    n_hit    = '0;
                    n_status = ST_OK;
                    n_owner  = '0;
                    n_slot   = '0;
                    n_x      = {15'd0, i_server_id};
                    rd_addr  = '0;
                    unique case (t_cmd'(i_command))
                        CMD_ADD: begin
                            if (32'(r_count) + 32'd3 > 32'(DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_MIX_A;
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_NOTFOUND;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_COUNT;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                rd_addr = r_count - 1'b1;
                                n_state = S_LOOK;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_MIX_A: begin
                n_x = rep_id;
                n_state = S_MIX_B;
            end
            S_MIX_B: begin
                n_x = mix_prod[31:0];
                n_state = S_MIX_C;
            end
            S_MIX_C: begin
                n_x = mix_prod[31:0];
                n_idx = '0;
                rd_addr = '0;
                n_state = S_FIND;
            end
            S_FIND: begin
                // r_rd_pos holds entry r_idx
                if (r_idx < r_count && r_rd_pos <= r_pos) begin
                    n_idx = r_idx + 1'b1;
                    rd_addr = r_idx + 1'b1;
                end else begin
                    // start shifting from the top
                    n_x = {{(32-AW){1'b0}}, r_idx};
                    n_idx = r_count;
                    rd_addr = r_count - 1'b1;
                    n_state = (r_idx == r_count) ? S_PUT : S_SHIFT;
                end
            end
            S_SHIFT: begin
                // move entry idx-1 up to idx
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_pos  = r_rd_pos;
                wr_own  = r_rd_own;
                n_idx   = r_idx - 1'b1;
                rd_addr = r_idx - 2'd2;
                if (r_idx - 1'b1 == r_x[AW-1:0]) n_state = S_PUT;
            end
            S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_x[AW-1:0];
                wr_pos  = r_pos;
                wr_own  = r_sid;
                n_count = r_count + 1'b1;
                if (r_rep == 2'd2) begin
                    n_state = S_DONE;
                end else begin
                    n_rep   = r_rep + 1'b1;
                    n_state = S_MIX_A;
                end
            end
            S_COUNT: begin
                // r_rd_own holds entry r_idx
                if (r_rd_own == r_sid && r_hit != 2'd3) n_hit = r_hit + 1'b1;
                if (r_idx + 1'b1 == r_count) begin
                    n_idx   = '0;
                    rd_addr = '0;
                    if ((r_rd_own == r_sid ? r_hit + 2'd1 : {1'b0, r_hit} == 2'd3 ?
                         2'd3 : r_hit) < 2'd3 &&
                        !(r_hit == 2'd3) && !(r_hit == 2'd2 && r_rd_own == r_sid)) begin
                        n_status = ST_NOTFOUND;
                        n_state  = S_DONE;
                    end else begin
                        n_hit   = '0;
                        n_x     = '0;
                        n_state = S_DEL;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    rd_addr = r_idx + 1'b1;
                end
            end
            S_DEL: begin
                // compacting copy: r_x is write pointer, r_idx read pointer
                if (r_rd_own == r_sid && r_hit != 2'd3) begin
                    n_hit = r_hit + 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_x[AW-1:0];
                    wr_pos  = r_rd_pos;
                    wr_own  = r_rd_own;
                    n_x     = r_x + 32'd1;
                end
                if (r_idx + 1'b1 == r_count) begin
                    n_count = r_count - AW'(3);
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    rd_addr = r_idx + 1'b1;
                end
            end
            S_LOOK: begin
                n_idx   = '0;
                rd_addr = '0;
                n_state = S_LOOK_RD;
                if (r_rd_pos < r_key) begin
                    n_state = S_DONE;
                    rd_addr = '0;
                    n_slot  = '0;
                    n_owner = '0;
                    n_x     = 32'd1;
                end else begin
                    n_x = '0;
                end
            end
            S_LOOK_RD: begin
                if (r_key <= r_rd_pos) begin
                    n_owner = r_rd_own;
                    n_slot  = 8'(r_idx);
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    rd_addr = r_idx + 1'b1;
                end
            end
            S_DONE: begin
                // wrap case takes owner of entry zero, read last cycle
                if (r_cmd == CMD_LOOKUP && r_status == ST_OK && r_x == 32'd1) begin
                    n_owner = r_rd_own;
                end
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_cmd <= i_command;
            r_sid <= i_server_id;
            r_key <= i_key_hash;
        end
        r_idx    <= n_idx;
        r_rep    <= n_rep;
        r_hit    <= n_hit;
        r_x      <= n_x;
        r_status <= n_status;
        r_owner  <= n_owner;
        r_slot   <= n_slot;
        if (r_state == S_MIX_C) r_pos <= (mix_prod[31:0] >> 16) ^ mix_prod[31:0];
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_owner_server = r_owner;
    assign o_owner_slot   = r_slot;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(DEPTH))
        else $error("entry count above ring depth");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_stall)
        else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_owner_server))
        else $error("result dropped under stall");
`endif

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// checks the hash ring unit against a behavioral ring: add, remove, lookup,
// full, empty and unknown-server cases, under random idling and stalls
// ----------------------------------------------------------------------------
module testbench;
    import chr_pkg::*;

    localparam int RING_DEPTH  = 192;
    localparam int CYCLE_LIMIT = 10000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [16:0] owner;
        logic [7:0]  slot;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_command;
    logic [16:0] i_server_id;
    logic [31:0] i_key_hash;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [16:0] o_owner_server;
    logic [7:0]  o_owner_slot;

    // behavioral ring
    logic [31:0] ring_pos[RING_DEPTH];
    logic [16:0] ring_own[RING_DEPTH];
    int          ring_len;
    t_answer     answer_queue[$];

    int          err_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;
    logic [16:0] live_ids[$];

    consistent_hash_ring_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_server_id    (i_server_id),
        .i_key_hash     (i_key_hash),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_owner_server (o_owner_server),
        .o_owner_slot   (o_owner_slot)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] avalanche(logic [31:0] x);
        logic [63:0] t;
        t = 64'(((x >> 16) ^ x)) * 64'(MIX_MUL);
        x = t[31:0];
        t = 64'(((x >> 16) ^ x)) * 64'(MIX_MUL);
        x = t[31:0];
        return (x >> 16) ^ x;
    endfunction

    function automatic void ring_insert(logic [31:0] pos, logic [16:0] own);
        int k;
        k = 0;
        while (k < ring_len && ring_pos[k] <= pos) k++;
        for (int i = ring_len; i > k; i--) begin
            ring_pos[i] = ring_pos[i-1];
            ring_own[i] = ring_own[i-1];
        end
        ring_pos[k] = pos;
        ring_own[k] = own;
        ring_len++;
    endfunction

    function automatic void ring_delete(int k);
        for (int i = k; i + 1 < ring_len; i++) begin
            ring_pos[i] = ring_pos[i+1];
            ring_own[i] = ring_own[i+1];
        end
        ring_len--;
    endfunction

    function automatic t_answer ring_apply(logic [1:0] cmd, logic [16:0] sid,
                                           logic [31:0] key);
        t_answer a;
        int      found;
        int      removed;
        int      i;
        int      k;
        a = '0;
        case (cmd)
            CMD_ADD: begin
                if (ring_len + 3 > RING_DEPTH) begin
                    a.status = ST_FULL;
                end else begin
                    ring_insert(avalanche(32'(sid)), sid);
                    ring_insert(avalanche(32'(sid) + 32'd100000), sid);
                    ring_insert(avalanche(32'(sid) + 32'd200000), sid);
                end
            end
            CMD_REMOVE: begin
                found = 0;
                for (i = 0; i < ring_len; i++) if (ring_own[i] == sid) found++;
                if (found < 3) begin
                    a.status = ST_NOTFOUND;
                end else begin
                    removed = 0;
                    i = 0;
                    while (i < ring_len && removed < 3) begin
                        if (ring_own[i] == sid) begin
                            ring_delete(i);
                            removed++;
                        end else begin
                            i++;
                        end
                    end
                end
            end
            CMD_LOOKUP: begin
                if (ring_len == 0) begin
                    a.status = ST_EMPTY;
                end else begin
                    k = 0;
                    if (ring_pos[ring_len-1] >= key) begin
                        for (i = 0; i < ring_len; i++) begin
                            if (key <= ring_pos[i]) begin
                                k = i;
                                break;
                            end
                        end
                    end
                    a.owner = ring_own[k];
                    a.slot  = 8'(k);
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic send_item(logic [1:0] cmd, logic [16:0] sid, logic [31:0] key);
        logic stalled;
        // waiting on the clock before each item keeps the drop of valid and the next item apart
        @(posedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_server_id <= sid;
        i_key_hash  <= key;
        // stall is sampled between edges, where it holds its value at the next edge
        do begin
            @(negedge i_clk);
            stalled = o_stall;
            @(posedge i_clk);
        end while (stalled);
        answer_queue.push_back(ring_apply(cmd, sid, key));
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (answer_queue.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // result check, sampled between edges for the next edge
    always @(negedge i_clk) begin
        t_answer exp_a;
        if (i_rst_n && o_valid && !i_stall) begin
            if (answer_queue.size() == 0) begin
                $error("result with no expectation: status %0d", o_status);
                err_count++;
            end else begin
                exp_a = answer_queue.pop_front();
                if (o_status !== exp_a.status) begin
                    $error("status: expected %0d actual %0d", exp_a.status, o_status);
                    err_count++;
                end
                if (o_owner_server !== exp_a.owner) begin
                    $error("owner_server: expected %0d actual %0d", exp_a.owner,
                           o_owner_server);
                    err_count++;
                end
                if (o_owner_slot !== exp_a.slot) begin
                    $error("owner_slot: expected %0d actual %0d", exp_a.slot,
                           o_owner_slot);
                    err_count++;
                end
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        i_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [16:0] pick_id();
        if (live_ids.size() != 0 && $urandom_range(3) != 0)
            return live_ids[$urandom_range(live_ids.size() - 1)];
        return 17'($urandom_range(31));
    endfunction

    task automatic test_directed();
        send_item(CMD_LOOKUP, 17'd0, 32'd0);
        send_item(CMD_REMOVE, 17'd5, 32'd0);
        send_item(CMD_NONE, 17'h1ffff, 32'hffff_ffff);
        send_item(CMD_ADD, 17'd0, 32'd0);
        send_item(CMD_LOOKUP, 17'd0, 32'd0);
        send_item(CMD_LOOKUP, 17'd0, 32'hffff_ffff);
        send_item(CMD_ADD, 17'h1ffff, 32'hffff_ffff);
        send_item(CMD_ADD, 17'd99999, 32'd0);
        send_item(CMD_ADD, 17'd99999, 32'd0);
        send_item(CMD_LOOKUP, 17'h1ffff, 32'h8000_0000);
        send_item(CMD_REMOVE, 17'd99999, 32'd0);
        send_item(CMD_REMOVE, 17'd99999, 32'd0);
        send_item(CMD_REMOVE, 17'd99999, 32'd0);
        send_item(CMD_REMOVE, 17'h1ffff, 32'd0);
        send_item(CMD_REMOVE, 17'd0, 32'd0);
        send_item(CMD_LOOKUP, 17'd0, 32'h1234_5678);
        wait_drained();
    endtask

    task automatic test_full_ring();
        // fill past capacity, then empty it again
        for (int i = 0; i < 66; i++) send_item(CMD_ADD, 17'(1000 + i), $urandom());
        send_item(CMD_LOOKUP, 17'd0, 32'hffff_ffff);
        send_item(CMD_LOOKUP, 17'd0, 32'd0);
        for (int i = 0; i < 64; i++) send_item(CMD_REMOVE, 17'(1000 + i), 32'd0);
        send_item(CMD_LOOKUP, 17'd0, $urandom());
        wait_drained();
    endtask

    task automatic test_random(int count);
        int          r;
        logic [16:0] sid;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 30) begin
                sid = ($urandom_range(9) == 0) ? 17'($urandom()) : 17'($urandom_range(63));
                send_item(CMD_ADD, sid, $urandom());
                live_ids.push_back(sid);
                if (live_ids.size() > 80) void'(live_ids.pop_front());
            end else if (r < 55) begin
                send_item(CMD_REMOVE, pick_id(), $urandom());
            end else if (r < 95) begin
                send_item(CMD_LOOKUP, 17'($urandom()), $urandom());
            end else begin
                send_item(CMD_NONE, 17'($urandom()), $urandom());
            end
        end
        wait_drained();
    endtask

    task automatic test_hold_off();
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++) send_item(CMD_LOOKUP, 17'd0, $urandom());
        join
        wait_drained();
    endtask

    initial begin
        err_count      = 0;
        cycle_count    = 0;
        ring_len       = 0;
        hold_off       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_command      = CMD_NONE;
        i_server_id    = '0;
        i_key_hash     = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_ring();
        test_random(500);
        send_idle_pct = 73;
        test_random(500);
        send_idle_pct  = 0;
        recv_stall_pct = 73;
        test_hold_off();
        test_random(500);
        send_idle_pct  = 27;
        recv_stall_pct = 27;
        test_random(500);

        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[consistent_hash_ring_unit.f]
design/chr_pkg.sv
design/consistent_hash_ring_unit.sv
sim/testbench.sv
